/* rtl/tcw_pkg.sv */
package tcw_pkg;

  // default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // character and attribute codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  // action codes carried on in_tuser
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // beat field widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 11;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  // sweep unit command
  typedef struct packed {
    logic       start;
    logic       copy;
    logic [7:0] color;
  } sweep_ctrl_t;

  // sweep unit status
  typedef struct packed {
    logic busy;
    logic running;
  } sweep_sts_t;

endpackage

/* rtl/tcw_ram.sv */
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcw_sweep.sv */
module tcw_sweep
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sweep_ctrl_t                    ctrl,
  output sweep_sts_t                     sts,
  output logic [$clog2(ROWS*COLS)-1:0]   raddr,
  input  logic [15:0]                    rdata,
  output logic                           we,
  output logic [$clog2(ROWS*COLS)-1:0]   waddr,
  output logic [15:0]                    wdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  logic          running_r, running_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          copy_r, copy_nxt;
  logic [7:0]    color_r, color_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          wcopy_r, wcopy_nxt;

  // cell counter, one cell per cycle
  always_comb begin
    running_nxt = running_r;
    idx_nxt     = idx_r;
    copy_nxt    = copy_r;
    color_nxt   = color_r;
    if (ctrl.start) begin
      running_nxt = 1'b1;
      idx_nxt     = '0;
      copy_nxt    = ctrl.copy;
      color_nxt   = ctrl.color;
    end else if (running_r) begin
      idx_nxt = idx_r + AW'(1);
      if (idx_r == AW'(CELLS - 1)) begin
        running_nxt = 1'b0;
      end
    end
  end

  // write stage trails the read, registered into the next cycle
  always_comb begin
    wv_nxt    = running_r;
    wa_nxt    = idx_r;
    wcopy_nxt = copy_r && (idx_r < AW'(CELLS - COLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b1;
      idx_r     <= '0;
      copy_r    <= 1'b0;
      color_r   <= RESET_COLOR;
      wv_r      <= 1'b0;
    end else begin
      running_r <= running_nxt;
      idx_r     <= idx_nxt;
      copy_r    <= copy_nxt;
      color_r   <= color_nxt;
      wv_r      <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r    <= wa_nxt;
    wcopy_r <= wcopy_nxt;
  end

  // source cell one line below, blank fill otherwise
  assign raddr = idx_r + AW'(COLS);
  assign we    = wv_r;
  assign waddr = wa_r;
  assign wdata = wcopy_r ? rdata : {color_r, SPACE_CODE};

  assign sts.busy    = running_r | wv_r;
  assign sts.running = running_r;

endmodule

/* rtl/text_console_cell_writer_unit.sv */
// put of a character or newline: next beat may follow at once
// read: waits in ST_READ for the registered memory read
// clear, and scroll on newline at the bottom: both run the sweep unit,
//   which touches one cell per cycle on the single write port
// reset: synchronous active low, then a clearing pass writes light-grey spaces
//   to every cell while in_tready stays low; cursor resets to 0,0
module text_console_cell_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // char_code[7:0], color[15:8], cell_index[26:16]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]   in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_data[15:0], cursor_row[20:16], cursor_col[27:21]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  state_t state_r, state_nxt;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] rb_r, rb_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [1:0]  action;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [31:0] index32;
  logic        accept;
  logic        is_nl;
  logic        at_last_row;
  logic        at_last_col;
  logic        need_scroll;
  logic        one_cycle;
  logic        out_load;
  logic [15:0] cell_out;
  logic [31:0] row32;
  logic [31:0] col32;

  sweep_ctrl_t sw_ctrl;
  sweep_sts_t  sw_sts;

  logic [AW-1:0] sw_raddr, sw_waddr;
  logic [15:0]   sw_wdata;
  logic          sw_we;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // input beat fields
  assign action    = in_tuser;
  assign char_code = in_tdata[7:0];
  assign color     = in_tdata[15:8];
  assign index32   = 32'(in_tdata[26:16]);
  assign accept    = in_tvalid & in_tready;

  assign is_nl       = (char_code == NEWLINE_CODE);
  assign at_last_row = (row_r == RW'(ROWS - 1));
  assign at_last_col = (col_r == CW'(COLS - 1));
  assign need_scroll = (action == ACT_PUT) && is_nl && at_last_row;
  assign one_cycle   = (action != ACT_CLEAR) && (action != ACT_READ) && !need_scroll;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (!sw_sts.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (action == ACT_READ) begin
            state_nxt = ST_READ;
          end else if (need_scroll) begin
            state_nxt = ST_SCROLL;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_SCROLL, ST_CLEAR: begin
        if (!sw_sts.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    out_load      = 1'b0;
    sw_ctrl.start = 1'b0;
    sw_ctrl.copy  = 1'b0;
    sw_ctrl.color = color;
    case (state_r)
      ST_IDLE: begin
        in_tready     = !out_valid_r || out_tready;
        out_load      = accept && one_cycle;
        sw_ctrl.start = accept && ((action == ACT_CLEAR) || need_scroll);
        sw_ctrl.copy  = need_scroll;
      end
      ST_READ: begin
        out_load = 1'b1;
      end
      ST_SCROLL, ST_CLEAR: begin
        out_load = !sw_sts.busy;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // cursor update and row base tracking
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    rb_nxt    = rb_r;
    rd_ok_nxt = rd_ok_r;
    if (accept) begin
      rd_ok_nxt = (index32 < 32'(CELLS));
      if (action == ACT_PUT) begin
        if (is_nl) begin
          col_nxt = '0;
          if (!at_last_row) begin
            row_nxt = row_r + RW'(1);
            rb_nxt  = rb_r + AW'(COLS);
          end
        end else if (at_last_col) begin
          col_nxt = '0;
          if (at_last_row) begin
            row_nxt = '0;
            rb_nxt  = '0;
          end else begin
            row_nxt = row_r + RW'(1);
            rb_nxt  = rb_r + AW'(COLS);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  // result beat
  assign row32    = 32'(row_nxt);
  assign col32    = 32'(col_nxt);
  assign cell_out = ((state_r == ST_READ) && rd_ok_r) ? ram_rdata : 16'h0000;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, col32[6:0], row32[4:0], cell_out};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      rb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rb_r        <= rb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // memory port selection
  assign ram_we    = sw_we || (accept && (action == ACT_PUT) && !is_nl);
  assign ram_waddr = sw_we ? sw_waddr : (rb_r + AW'(col_r));
  assign ram_wdata = sw_we ? sw_wdata : {color, char_code};
  assign ram_raddr = sw_sts.running ? sw_raddr : index32[AW-1:0];

  tcw_sweep #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_sweep (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (sw_ctrl),
    .sts  (sw_sts),
    .raddr(sw_raddr),
    .rdata(ram_rdata),
    .we   (sw_we),
    .waddr(sw_waddr),
    .wdata(sw_wdata)
  );

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef ASSERT_OFF
  // no beat is taken while the sweep owns the memory
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sw_sts.busy)
    else $error("input ready during sweep");

  // items other than read, clear and scroll deliver their result on the next edge
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && one_cycle) |=> out_valid_r)
    else $error("missing result after single-cycle item");

  // row base always matches the cursor row
  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rb_r) == 32'(row_r) * 32'(COLS))
    else $error("row base out of step with cursor row");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLS)))
    else $error("cursor off screen");

  // a waiting result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("result overwritten");
`endif

endmodule
